// ----- rtl/srt_pkg.sv -----
// ----------------------------------------------------------------------------
// srt_pkg
// Shared types and constants for the sorted record table: channel payloads,
// record layout, status codes and the command and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package srt_pkg;

    localparam int KEY_W            = 32;
    localparam int SCORE_W          = 14;
    localparam int TOTAL_W          = 6;
    localparam int STATUS_W         = 2;
    localparam int DEFAULT_CAPACITY = 32;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

    typedef struct packed {
        logic               action;
        logic [KEY_W-1:0]   key;
        logic [SCORE_W-1:0] score;
    } srt_in_t;

    typedef struct packed {
        logic [KEY_W-1:0]    out_key;
        logic [SCORE_W-1:0]  out_score;
        logic [TOTAL_W-1:0]  record_total;
        logic [STATUS_W-1:0] status;
        logic                empty_res;
        logic                last;
    } srt_out_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [SCORE_W-1:0] score;
    } srt_rec_t;

    typedef struct packed {
        logic                item_load;
        logic                rd_en;
        logic                wr_en;
        logic                wr_from_item;
        logic                out_load;
        logic                out_empty;
        logic                out_last;
        logic [STATUS_W-1:0] status;
    } srt_cmd_t;

    typedef struct packed {
        logic is_delete;
        logic key_ge;
        logic key_eq;
        logic out_free;
    } srt_stat_t;

endpackage

// ----- rtl/srt_dp.sv -----
// ----------------------------------------------------------------------------
// srt_dp
// Datapath of the sorted record table: record memory with registered read
// data, the held input item, key comparators and the output register.
// ----------------------------------------------------------------------------
module srt_dp
    import srt_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY,
    localparam int AW = $clog2(CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  srt_cmd_t      cmd,
    input  logic [AW-1:0] rd_addr,
    input  logic [AW-1:0] wr_addr,
    input  logic [CW-1:0] record_count,
    input  srt_in_t       s_item,
    output srt_stat_t     stat,
    output logic          m_valid,
    input  logic          m_ready,
    output srt_out_t      m_item
);

    srt_rec_t rec_mem_reg [CAPACITY];
    srt_rec_t rdata_reg;
    srt_rec_t wdata_next;
    srt_in_t  item_reg;
    logic     m_valid_reg;
    srt_out_t m_item_reg;
    srt_out_t m_item_next;

    // Shifted records come straight from the read register.
    always_comb begin
        if (cmd.wr_from_item) begin
            wdata_next.key   = item_reg.key;
            wdata_next.score = item_reg.score;
        end else begin
            wdata_next = rdata_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            rec_mem_reg[wr_addr] <= wdata_next;
        end
        if (cmd.rd_en) begin
            rdata_reg <= rec_mem_reg[rd_addr];
        end
        if (cmd.item_load) begin
            item_reg <= s_item;
        end
    end

    always_comb begin
        stat.is_delete = (item_reg.action == ACT_DELETE);
        stat.key_ge    = (rdata_reg.key >= item_reg.key);
        stat.key_eq    = (rdata_reg.key == item_reg.key);
        stat.out_free  = !m_valid_reg || m_ready;
    end

    always_comb begin
        if (cmd.out_empty) begin
            m_item_next.out_key   = '0;
            m_item_next.out_score = '0;
            m_item_next.empty_res = 1'b1;
        end else begin
            m_item_next.out_key   = rdata_reg.key;
            m_item_next.out_score = rdata_reg.score;
            m_item_next.empty_res = 1'b0;
        end
        m_item_next.record_total = TOTAL_W'(record_count);
        m_item_next.status       = cmd.status;
        m_item_next.last         = cmd.out_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            m_item_reg <= m_item_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

// ----- rtl/srt_ctrl.sv -----
// ----------------------------------------------------------------------------
// srt_ctrl
// Controller of the sorted record table: sequences the insert scan, the
// delete scan, the final write and the listing, and keeps the record count.
// ----------------------------------------------------------------------------
module srt_ctrl
    import srt_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY,
    localparam int AW = $clog2(CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  srt_stat_t     stat,
    output srt_cmd_t      cmd,
    output logic [AW-1:0] rd_addr,
    output logic [AW-1:0] wr_addr,
    output logic [CW-1:0] record_count
);

    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_INS_SCAN,
        S_INS_PUT,
        S_DEL_SCAN,
        S_LIST,
        S_LIST_EMPTY
    } state_t;

    state_t              state_reg,  state_next;
    logic [CW-1:0]       count_reg,  count_next;
    logic [CW-1:0]       idx_reg,    idx_next;
    logic [AW-1:0]       pidx_reg,   pidx_next;
    logic [AW-1:0]       pos_reg,    pos_next;
    logic                pend_reg,   pend_next;
    logic                found_reg,  found_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic [CW-1:0] idx_dec;
    logic [CW-1:0] pidx_inc;
    logic [CW-1:0] count_dec;

    assign idx_dec   = idx_reg - CW'(1);
    assign pidx_inc  = CW'(pidx_reg) + CW'(1);
    assign count_dec = count_reg - CW'(1);

    always_comb begin
        logic stay;
        logic issue;

        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        pidx_next   = pidx_reg;
        pos_next    = pos_reg;
        pend_next   = pend_reg;
        found_next  = found_reg;
        status_next = status_reg;
        cmd         = '0;
        cmd.status  = status_reg;
        rd_addr     = idx_reg[AW-1:0];
        wr_addr     = pos_reg;
        stay        = 1'b1;
        issue       = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.item_load = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE: begin
                pend_next   = 1'b0;
                status_next = STATUS_DONE;
                if (stat.is_delete) begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    state_next = S_DEL_SCAN;
                end else if (count_reg == CAP_CNT) begin
                    status_next = STATUS_FULL;
                    idx_next    = '0;
                    state_next  = S_LIST;
                end else begin
                    idx_next   = count_reg;
                    state_next = S_INS_SCAN;
                end
            end
            S_INS_SCAN: begin
                // Walk down from the top; every key not below the new one
                // moves up a place, the first smaller key ends the walk.
                if (pend_reg) begin
                    if (stat.key_ge) begin
                        cmd.wr_en = 1'b1;
                        wr_addr   = AW'(pidx_inc);
                        if (pidx_reg == '0) begin
                            pos_next = '0;
                            stay     = 1'b0;
                        end
                    end else begin
                        pos_next = AW'(pidx_inc);
                        stay     = 1'b0;
                    end
                end else if (idx_reg == '0) begin
                    pos_next = '0;
                    stay     = 1'b0;
                end
                if (stay && (idx_reg != '0)) begin
                    cmd.rd_en = 1'b1;
                    rd_addr   = idx_dec[AW-1:0];
                    pidx_next = idx_dec[AW-1:0];
                    idx_next  = idx_dec;
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                end
                if (!stay) begin
                    state_next = S_INS_PUT;
                end
            end
            S_INS_PUT: begin
                cmd.wr_en        = 1'b1;
                cmd.wr_from_item = 1'b1;
                count_next       = count_reg + CW'(1);
                idx_next         = '0;
                pend_next        = 1'b0;
                state_next       = S_LIST;
            end
            S_DEL_SCAN: begin
                // Once the first match is seen, each later record drops by one.
                if (pend_reg) begin
                    if (found_reg) begin
                        cmd.wr_en = 1'b1;
                        wr_addr   = pidx_reg - AW'(1);
                    end else if (stat.key_eq) begin
                        found_next = 1'b1;
                    end
                end
                if (idx_reg != count_reg) begin
                    cmd.rd_en = 1'b1;
                    rd_addr   = idx_reg[AW-1:0];
                    pidx_next = idx_reg[AW-1:0];
                    idx_next  = idx_reg + CW'(1);
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        idx_next = '0;
                        if (found_reg) begin
                            count_next  = count_dec;
                            status_next = STATUS_DONE;
                            state_next  = (count_dec == '0) ? S_LIST_EMPTY : S_LIST;
                        end else begin
                            status_next = STATUS_NOT_FOUND;
                            state_next  = (count_reg == '0) ? S_LIST_EMPTY : S_LIST;
                        end
                    end
                end
            end
            S_LIST: begin
                if (pend_reg && stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = (pidx_inc == count_reg);
                end
                issue = (idx_reg != count_reg) && (!pend_reg || stat.out_free);
                if (issue) begin
                    cmd.rd_en = 1'b1;
                    rd_addr   = idx_reg[AW-1:0];
                    pidx_next = idx_reg[AW-1:0];
                    idx_next  = idx_reg + CW'(1);
                end
                pend_next = issue || (pend_reg && !stat.out_free);
                if ((idx_reg == count_reg) && (!pend_reg || stat.out_free)) begin
                    state_next = S_IDLE;
                end
            end
            S_LIST_EMPTY: begin
                if (stat.out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_empty = 1'b1;
                    cmd.out_last  = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            pidx_reg   <= '0;
            pos_reg    <= '0;
            pend_reg   <= 1'b0;
            found_reg  <= 1'b0;
            status_reg <= STATUS_DONE;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            pidx_reg   <= pidx_next;
            pos_reg    <= pos_next;
            pend_reg   <= pend_next;
            found_reg  <= found_next;
            status_reg <= status_next;
        end
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign record_count = count_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_CNT)
        else $error("record count exceeds capacity");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> stat.out_free)
        else $error("output register loaded while still occupied");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (count_reg != $past(count_reg))) |->
            ($past(state_reg) == S_INS_PUT || $past(state_reg) == S_DEL_SCAN))
        else $error("record count changed outside insert or delete");

    a_insert_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_INS_PUT) |-> (count_reg < CAP_CNT))
        else $error("insert write with a full table");

    a_list_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LIST && pend_reg) |-> (CW'(pidx_reg) < count_reg))
        else $error("listing read beyond the held records");
`endif

endmodule

// ----- rtl/sorted_record_table_top.sv -----
// ----------------------------------------------------------------------------
// sorted_record_table_top
// Sorted record table: keeps up to CAPACITY (key, score) records in
// ascending key order, inserts and deletes one record per item and lists the
// whole table after every item.
// ----------------------------------------------------------------------------
// The block takes one item at a time and holds off the next until the current
// item's listing has been handed to the output register. An insert is
// accepted, decoded, scanned, finished with the final write and then listed;
// a delete is accepted, decoded, scanned and listed, and an insert into a full
// table skips the scan and the final write. The single record memory has one
// write and one registered read port, so both the scan and the listing move
// one record per cycle, the listing only while the output register is free.
// An insert walks down from the top record and moves every record whose key
// is not below the new key up by one place, so a new record goes ahead of
// records with an equal key; the first smaller key marks the place for the
// new record. A delete walks up from the bottom and, after the first record
// with a matching key, moves each later record down by one. An insert into a
// full table leaves it unchanged and is flagged in status; a delete of a key
// that is not held is flagged likewise. Every result item carries the record
// total and the status of the item that caused it, and the final result of a
// listing has last set. An empty table is listed as a single result item with
// empty_res set and zero key and score. The memory needs no clearing after
// reset, since only records below the count are ever read. Both channels use
// a valid and ready handshake; the output register lets the last result wait
// for the consumer while the next item is accepted.
// ----------------------------------------------------------------------------
module sorted_record_table_top
    import srt_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  srt_in_t  s_item,
    output logic     m_valid,
    input  logic     m_ready,
    output srt_out_t m_item
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    srt_cmd_t      cmd;
    srt_stat_t     stat;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [CW-1:0] record_count;

    // Sequencing of scans, writes and the listing.
    srt_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .stat         (stat),
        .cmd          (cmd),
        .rd_addr      (rd_addr),
        .wr_addr      (wr_addr),
        .record_count (record_count)
    );

    // Record memory, comparators and the output register.
    srt_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .rd_addr      (rd_addr),
        .wr_addr      (wr_addr),
        .record_count (record_count),
        .s_item       (s_item),
        .stat         (stat),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_item       (m_item)
    );

endmodule
